// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on aclk that is switched off while aresetn is low.
`define NSPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent assertion on aclk that also holds across reset.
`define NSPC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/nspc_pkg.sv -----
// Package with types, codes and the pixel conversion of the scaler.
`default_nettype none

package nspc_pkg;

    // Default output geometry and line store depth.
    localparam int OUT_WIDTH_DEF  = 1920;
    localparam int OUT_HEIGHT_DEF = 1080;
    localparam int LINE_DEPTH_DEF = 2048;

    // Field widths.
    localparam int COL_W  = 11;
    localparam int IDX_W  = 11;
    localparam int PIX_W  = 32;
    localparam int ROW_W  = 11;
    localparam int DIM_W  = 12;
    // Index times dimension, and the reciprocal multiply that follows it.
    localparam int PROD_W  = IDX_W + DIM_W;
    localparam int RECIP_W = PROD_W + 2;
    localparam int MULT_W  = PROD_W + RECIP_W;

    // Request codes.
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PIXEL = 2'd1;
    localparam logic [1:0] REQ_ROW   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 2'd2;

    // Source pixel formats.
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_ARGB   = 1'b1;

    // Register reset values.
    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd1080;
    localparam logic             FORMAT_RST = FMT_ARGB;

    // Largest source row that the row field can carry.
    localparam logic [ROW_W-1:0] ROW_MAX = 11'h7ff;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] pixel_in;
        logic [IDX_W-1:0] out_index;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [ROW_W-1:0] src_row;
        logic             reload;
    } out_item_t;

    // Convert a stored pixel to byte order red, green, blue, alpha.
    function automatic logic [PIX_W-1:0] convert_pixel(input logic [PIX_W-1:0] v,
                                                       input logic fmt);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        if (fmt == FMT_RGB565) begin
            r8 = {v[15:11], v[15:13]};
            g8 = {v[10:5], v[10:9]};
            b8 = {v[4:0], v[4:2]};
        end else begin
            r8 = v[23:16];
            g8 = v[15:8];
            b8 = v[7:0];
        end
        return {8'hff, b8, g8, r8};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nspc_scale_pipe.sv -----
// Two-stage coordinate scaler: index times size, then exact division by the output size.
`default_nettype none

module nspc_scale_pipe #(
    parameter int OUT_WIDTH  = nspc_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = nspc_pkg::OUT_HEIGHT_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire nspc_pkg::in_item_t         in_item,
    input  wire logic [nspc_pkg::DIM_W-1:0] src_width,
    input  wire logic [nspc_pkg::DIM_W-1:0] src_height,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      nspc_pkg::in_item_t         out_item,
    output      logic [nspc_pkg::PROD_W-1:0] out_quot
);
    import nspc_pkg::*;

    // Reciprocals that make floor(p * M >> S) equal floor(p / D) for every product p.
    localparam int W_SHIFT = PROD_W + $clog2(OUT_WIDTH);
    localparam int H_SHIFT = PROD_W + $clog2(OUT_HEIGHT);
    localparam logic [63:0] W_RECIP64 =
        ((64'd1 << W_SHIFT) + 64'(OUT_WIDTH) - 64'd1) / 64'(OUT_WIDTH);
    localparam logic [63:0] H_RECIP64 =
        ((64'd1 << H_SHIFT) + 64'(OUT_HEIGHT) - 64'd1) / 64'(OUT_HEIGHT);
    localparam logic [RECIP_W-1:0] W_RECIP = RECIP_W'(W_RECIP64);
    localparam logic [RECIP_W-1:0] H_RECIP = RECIP_W'(H_RECIP64);

    logic               v1_reg;
    logic               v1_next;
    in_item_t           item1_reg;
    logic [PROD_W-1:0]  prod1_reg;
    logic [PROD_W-1:0]  prod1_next;
    logic               v2_reg;
    logic               v2_next;
    in_item_t           item2_reg;
    logic [MULT_W-1:0]  prod2_reg;
    logic [MULT_W-1:0]  prod2_next;
    logic [DIM_W-1:0]   scale;
    logic [RECIP_W-1:0] recip;
    logic               en1;
    logic               en2;

    // A stage loads when it is empty or its item moves on.
    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // First stage multiplies the index by the source size.
    always_comb begin
        scale      = (in_item.req_type == REQ_ROW) ? src_height : src_width;
        prod1_next = PROD_W'(in_item.out_index) * PROD_W'(scale);
        v1_next    = en1 ? in_valid : v1_reg;
    end

    // Second stage multiplies by the reciprocal of the output size.
    always_comb begin
        recip      = (item1_reg.req_type == REQ_ROW) ? H_RECIP : W_RECIP;
        prod2_next = MULT_W'(prod1_reg) * MULT_W'(recip);
        v2_next    = en2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            item1_reg <= in_item;
            prod1_reg <= prod1_next;
        end
        if (en2 && v1_reg) begin
            item2_reg <= item1_reg;
            prod2_reg <= prod2_next;
        end
    end

    // The shift completes the division.
    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_quot  = (item2_reg.req_type == REQ_ROW) ? PROD_W'(prod2_reg >> H_SHIFT)
                                                       : PROD_W'(prod2_reg >> W_SHIFT);

endmodule

`default_nettype wire

// ----- rtl/core/nspc_line_store.sv -----
// Single-port line store with a registered read.
`default_nettype none

module nspc_line_store #(
    parameter int LINE_DEPTH = nspc_pkg::LINE_DEPTH_DEF,
    parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          addr,
    input  wire logic [nspc_pkg::PIX_W-1:0] wr_data,
    output      logic [nspc_pkg::PIX_W-1:0] rd_data
);
    import nspc_pkg::*;

    logic [PIX_W-1:0] mem [LINE_DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    // Write and read share the port; the read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nearest_scaler_pixel_convert.sv -----
// Top level of the nearest-neighbor scaler with pixel format conversion.
//
//   Port group   Role     Handshake          Payload
//   s_*          items    s_valid/s_ready    s_item   (nspc_pkg::in_item_t)
//   m_*          results  m_valid/m_ready    m_item   (nspc_pkg::out_item_t)
//   cfg_*        config   cfg_wr_en          cfg_index, cfg_wdata
//
// One item is accepted per clock while the output is not stalled. A result reaches the
// output register after two multiplier stages, then the line store read port.
// Every stage moves on its own, so bubbles close up while the output waits.
// Reset clears the pipeline, the row tracking and the registers; the line store is
// not cleared and needs no pass after reset.
`default_nettype none

module nearest_scaler_pixel_convert #(
    parameter int OUT_WIDTH  = nspc_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = nspc_pkg::OUT_HEIGHT_DEF,
    parameter int LINE_DEPTH = nspc_pkg::LINE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire nspc_pkg::in_item_t             s_item,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      nspc_pkg::out_item_t            m_item,
    input  wire logic                           cfg_wr_en,
    input  wire logic [nspc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nspc_pkg::DIM_W-1:0]     cfg_wdata
);
    import nspc_pkg::*;

    localparam int ADDR_W = $clog2(LINE_DEPTH);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic              format_reg;

    logic              sc_valid;
    logic              sc_ready;
    in_item_t          sc_item;
    logic [PROD_W-1:0] sc_quot;

    logic              take3;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] col_addr;
    logic [PIX_W-1:0]  rd_data;
    logic [ROW_W-1:0]  row_calc;
    logic              reload_calc;

    logic              v3_reg;
    logic              v3_next;
    logic [1:0]        req3_reg;
    logic [ROW_W-1:0]  row3_reg;
    logic              reload3_reg;
    logic [ROW_W-1:0]  last_row_reg;
    logic [ROW_W-1:0]  last_row_next;
    logic              last_valid_reg;
    logic              last_valid_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_item_reg;
    out_item_t         m_item_next;
    logic              en3;
    logic              en4;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            format_reg <= FORMAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  width_reg  <= cfg_wdata;
                CFG_SOURCE_HEIGHT: height_reg <= cfg_wdata;
                CFG_PIXEL_FORMAT:  format_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Column and row mapping.
    nspc_scale_pipe #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (s_item),
        .src_width  (width_reg),
        .src_height (height_reg),
        .out_valid  (sc_valid),
        .out_ready  (sc_ready),
        .out_item   (sc_item),
        .out_quot   (sc_quot)
    );

    // Stage handshakes back from the output register.
    assign en4      = !m_valid_reg || m_ready;
    assign en3      = !v3_reg || en4;
    assign sc_ready = en3;
    assign take3    = sc_valid && en3;

    // Line store access: loads within the store depth write, pixel items read, both in item order.
    always_comb begin
        col_addr = (sc_quot > PROD_W'(LINE_DEPTH - 1)) ? ADDR_W'(LINE_DEPTH - 1)
                                                       : ADDR_W'(sc_quot);
        mem_addr = (sc_item.req_type == REQ_LOAD) ? ADDR_W'(sc_item.column) : col_addr;
        wr_en    = take3 && (sc_item.req_type == REQ_LOAD)
                   && (32'(sc_item.column) < LINE_DEPTH);
        rd_en    = take3 && (sc_item.req_type == REQ_PIXEL);
    end

    nspc_line_store #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .addr    (mem_addr),
        .wr_data (sc_item.pixel_in),
        .rd_data (rd_data)
    );

    // Row mapping: clamp the row and compare it with the last mapped one; index zero or no earlier row forces a reload.
    always_comb begin
        row_calc    = (sc_quot > PROD_W'(ROW_MAX)) ? ROW_MAX : ROW_W'(sc_quot);
        reload_calc = (sc_item.out_index == '0) || !last_valid_reg
                      || (row_calc != last_row_reg);
        v3_next         = en3 ? sc_valid : v3_reg;
        last_row_next   = last_row_reg;
        last_valid_next = last_valid_reg;
        if (take3 && (sc_item.req_type == REQ_ROW)) begin
            last_row_next   = row_calc;
            last_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg         <= 1'b0;
            last_row_reg   <= '0;
            last_valid_reg <= 1'b0;
        end else begin
            v3_reg         <= v3_next;
            last_row_reg   <= last_row_next;
            last_valid_reg <= last_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take3) begin
            req3_reg    <= sc_item.req_type;
            row3_reg    <= row_calc;
            reload3_reg <= reload_calc;
        end
    end

    // Output register: only pixel and row items produce a result.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (en4) begin
            m_valid_next = v3_reg && ((req3_reg == REQ_PIXEL) || (req3_reg == REQ_ROW));
            if (req3_reg == REQ_PIXEL) begin
                m_item_next.out_pixel = convert_pixel(rd_data, format_reg);
                m_item_next.src_row   = '0;
                m_item_next.reload    = 1'b0;
            end else begin
                m_item_next.out_pixel = '0;
                m_item_next.src_row   = row3_reg;
                m_item_next.reload    = reload3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nspc_checker.sv -----
// Port-level checker for the scaler, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module nspc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire nspc_pkg::out_item_t m_item
);
    import nspc_pkg::*;

    logic shape_ok;

    // A row result carries no pixel; a pixel result is opaque and has no row fields.
    assign shape_ok = (m_item.out_pixel == '0)
                      || ((m_item.out_pixel[31:24] == 8'hff) && (m_item.src_row == '0)
                          && !m_item.reload);

    // Reset empties the result register.
    `NSPC_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

    // An empty pipeline after reset takes an item at once.
    `NSPC_ASSERT_RST(a_reset_ready, !aresetn |=> s_ready, "input not ready after reset")

    // A stalled result holds.
    `NSPC_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_item), "result not held")

    // Every result has one of the two legal shapes.
    `NSPC_ASSERT(a_shape, m_valid |-> shape_ok, "malformed result")

endmodule

bind nearest_scaler_pixel_convert nspc_checker u_checker (.*);

`default_nettype wire
